>>> hdl/assert_macros.svh
// Assertion macros shared by the sorted alarm queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SAQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted alarm queue check failed");

// Next-cycle implication, checked outside reset.
`define SAQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted alarm queue check failed");

`endif

>>> hdl/saq_pkg.sv
// Package: types, codes and helpers of the sorted alarm queue.
`timescale 1ns / 1ps
`default_nettype none
package saq_pkg;

    localparam int ALARM_SLOTS = 8;
    localparam int SLOT_W      = $clog2(ALARM_SLOTS);
    localparam int TIME_W      = 64;
    localparam int CNT_W       = $clog2(TIME_W);

    typedef enum logic [1:0] {
        FUNC_SET_ONE = 2'd0,
        FUNC_SET_PER = 2'd1,
        FUNC_CANCEL  = 2'd2,
        FUNC_FIRE    = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REMOVE,
        ST_CALC,
        ST_DIV,
        ST_INSERT,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        OP_NOP,
        OP_REMOVE,
        OP_INSERT
    } cell_op_t;

    // One queue entry held by a cell
    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] slot;
        logic [TIME_W-1:0] fire_time;
    } entry_t;

    // Command broadcast to every cell
    typedef struct packed {
        cell_op_t          op;
        logic [SLOT_W-1:0] target;
        logic [TIME_W-1:0] new_time;
    } cell_ctl_t;

    // Flags rippling from a cell to its right-hand neighbour
    typedef struct packed {
        logic gt;
        logic open;
        logic rm;
    } chain_t;

    // Signed less-than on raw two's complement patterns
    function automatic logic s_lt(input logic [TIME_W-1:0] a, input logic [TIME_W-1:0] b);
        logic [TIME_W-1:0] sign;
        sign = {1'b1, {(TIME_W-1){1'b0}}};
        return (a ^ sign) < (b ^ sign);
    endfunction

endpackage
`default_nettype wire

>>> hdl/saq_if.sv
// Interfaces: request and response channels of the sorted alarm queue.
`timescale 1ns / 1ps
`default_nettype none
interface saq_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         func;
    logic [2:0]         slot;
    logic signed [63:0] now;
    logic signed [63:0] time_value;
    logic signed [63:0] period_value;

    modport source (output valid, func, slot, now, time_value, period_value, input ready);
    modport sink (input valid, func, slot, now, time_value, period_value, output ready);
endinterface

interface saq_rsp_if;
    logic       valid;
    logic       ready;
    logic       fired;
    logic [2:0] fired_slot;

    modport source (output valid, fired, fired_slot, input ready);
    modport sink (input valid, fired, fired_slot, output ready);
endinterface
`default_nettype wire

>>> hdl/saq_cell.sv
// Module: one cell of the sorted queue chain, holding one alarm entry.
`timescale 1ns / 1ps
`default_nettype none
module saq_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire saq_pkg::cell_ctl_t ctl,
    input  wire saq_pkg::entry_t    left,
    input  wire saq_pkg::chain_t    chain_in,
    input  wire saq_pkg::entry_t    right,
    output saq_pkg::entry_t         ent,
    output saq_pkg::chain_t         chain_out
);
    import saq_pkg::*;

    entry_t ent_reg;
    entry_t ent_next;
    logic   gt;
    logic   take_new;

    // Compare against the broadcast time and ripple the flags onward
    always_comb
    begin
        gt             = ent_reg.valid && s_lt(ctl.new_time, ent_reg.fire_time);
        take_new       = chain_in.open && (gt || !ent_reg.valid);
        chain_out.gt   = gt;
        chain_out.open = ent_reg.valid && !gt;
        chain_out.rm   = chain_in.rm || (ent_reg.valid && (ent_reg.slot == ctl.target));
    end

    // Shift left on removal, shift right or load on insertion
    always_comb
    begin
        ent_next = ent_reg;
        case (ctl.op)
            OP_REMOVE:
            begin
                if (chain_out.rm)
                begin
                    ent_next = right;
                end
            end
            OP_INSERT:
            begin
                if (chain_in.gt)
                begin
                    ent_next = left;
                end
                else if (take_new)
                begin
                    ent_next = '{valid: 1'b1, slot: ctl.target, fire_time: ctl.new_time};
                end
            end
            default:
            begin
                ent_next = ent_reg;
            end
        endcase
    end

    // Hold the entry; clear it on reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_reg <= '0;
        end
        else
        begin
            ent_reg <= ent_next;
        end
    end

    assign ent = ent_reg;

endmodule
`default_nettype wire

>>> hdl/saq_div.sv
// Module: bit-serial restoring divider that yields the remainder only.
`timescale 1ns / 1ps
`default_nettype none
module saq_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [saq_pkg::TIME_W-1:0]  dividend,
    input  wire logic [saq_pkg::TIME_W-1:0]  divisor,
    output logic                             busy,
    output logic                             done,
    output logic [saq_pkg::TIME_W-1:0]       remainder
);
    import saq_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [TIME_W-1:0] dvd_reg;
    logic [TIME_W-1:0] dvs_reg;
    logic [TIME_W-1:0] rem_reg;
    logic [TIME_W:0]   trial;
    logic [TIME_W:0]   diff;

    // Bring down one dividend bit and try the subtraction
    always_comb
    begin
        trial = {rem_reg, dvd_reg[TIME_W-1]};
        diff  = trial - {1'b0, dvs_reg};
    end

    // Control: count the iterations
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(TIME_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: keep the partial remainder
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[TIME_W-2:0], 1'b0};
            rem_reg <= diff[TIME_W] ? trial[TIME_W-1:0] : diff[TIME_W-1:0];
        end
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule
`default_nettype wire

>>> hdl/sorted_alarm_queue.sv
// Sorted alarm queue: a chain of cells kept in fire-time order, one sequencer on top.
// Operations are taken one at a time. A periodic set, and a fire head that re-queues
// a periodic alarm, wait on the catch-up remainder when start lies before now; that
// remainder comes from a bit-serial divider that retires one bit per cycle over 64
// bits. Removal and insertion each update the whole cell chain at once. A result
// waits in an output register and the next request is taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none
module sorted_alarm_queue (
    input  wire logic clk,
    input  wire logic rst_n,
    saq_req_if.sink   req,
    saq_rsp_if.source rsp
);
    import saq_pkg::*;

    state_t              state_reg;
    state_t              state_next;
    func_t               func_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [TIME_W-1:0]   now_reg;
    logic [TIME_W-1:0]   tv_reg;
    logic [TIME_W-1:0]   per_reg;
    logic [TIME_W-1:0]   st_reg;
    logic [TIME_W-1:0]   fire_reg;
    logic [TIME_W-1:0]   fire_next;
    logic                fired_reg;
    logic                rsp_valid_reg;
    logic                rsp_fired_reg;
    logic [2:0]          rsp_slot_reg;
    logic [TIME_W-1:0]   periods_reg [ALARM_SLOTS];
    logic [TIME_W-1:0]   starts_reg [ALARM_SLOTS];

    cell_ctl_t           ctl;
    entry_t              ents [ALARM_SLOTS];
    chain_t              links [ALARM_SLOTS];
    logic [ALARM_SLOTS-1:0] valid_vec;

    logic                req_beat;
    logic                slot_ok;
    logic                head_due;
    logic                div_start;
    logic                div_busy;
    logic                div_done;
    logic [TIME_W-1:0]   div_rem;
    logic                load_rsp;

    assign req_beat  = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign slot_ok   = (32'(req.slot) < ALARM_SLOTS);
    assign head_due  = ents[0].valid && !s_lt(req.now, ents[0].fire_time);

    // Cell chain
    for (genvar i = 0; i < ALARM_SLOTS; i++)
    begin : g_cell
        entry_t l_ent;
        entry_t r_ent;
        chain_t c_in;
        if (i == 0)
        begin : g_first
            assign l_ent = '0;
            assign c_in  = '{gt: 1'b0, open: 1'b1, rm: 1'b0};
        end
        else
        begin : g_mid
            assign l_ent = ents[i-1];
            assign c_in  = links[i-1];
        end
        if (i == ALARM_SLOTS - 1)
        begin : g_last
            assign r_ent = '0;
        end
        else
        begin : g_inner
            assign r_ent = ents[i+1];
        end
        saq_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .left      (l_ent),
            .chain_in  (c_in),
            .right     (r_ent),
            .ent       (ents[i]),
            .chain_out (links[i])
        );
        assign valid_vec[i] = ents[i].valid;
    end

    // Catch-up remainder unit
    saq_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (now_reg - st_reg),
        .divisor   (per_reg),
        .busy      (div_busy),
        .done      (div_done),
        .remainder (div_rem)
    );

    // Sequencer: next state, cell command and fire time
    always_comb
    begin
        state_next   = state_reg;
        fire_next    = fire_reg;
        div_start    = 1'b0;
        load_rsp     = 1'b0;
        ctl.op       = OP_NOP;
        ctl.target   = slot_reg;
        ctl.new_time = fire_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_beat)
                begin
                    if (func_t'(req.func) == FUNC_FIRE)
                    begin
                        state_next = head_due ? ST_REMOVE : ST_DONE;
                    end
                    else
                    begin
                        state_next = slot_ok ? ST_REMOVE : ST_DONE;
                    end
                end
            end
            ST_REMOVE:
            begin
                ctl.op = OP_REMOVE;
                case (func_reg)
                    FUNC_CANCEL:
                    begin
                        state_next = ST_DONE;
                    end
                    FUNC_SET_ONE:
                    begin
                        fire_next  = now_reg + tv_reg;
                        state_next = ST_INSERT;
                    end
                    FUNC_SET_PER:
                    begin
                        state_next = ST_CALC;
                    end
                    FUNC_FIRE:
                    begin
                        state_next = s_lt('0, periods_reg[slot_reg]) ? ST_CALC : ST_DONE;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_CALC:
            begin
                if (!s_lt('0, per_reg))
                begin
                    fire_next  = '0;
                    state_next = ST_INSERT;
                end
                else if (s_lt(st_reg, now_reg))
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
                else
                begin
                    fire_next  = st_reg;
                    state_next = ST_INSERT;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    fire_next  = now_reg - div_rem + per_reg;
                    state_next = ST_INSERT;
                end
            end
            ST_INSERT:
            begin
                ctl.op     = OP_INSERT;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    load_rsp   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_rsp)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Latch the request, the slot settings and the result
    always_ff @(posedge clk)
    begin
        fire_reg <= fire_next;
        if (req_beat)
        begin
            func_reg <= func_t'(req.func);
            now_reg  <= req.now;
            tv_reg   <= req.time_value;
            if (func_t'(req.func) == FUNC_FIRE)
            begin
                slot_reg  <= ents[0].slot;
                fired_reg <= head_due;
            end
            else
            begin
                slot_reg  <= SLOT_W'(req.slot);
                fired_reg <= 1'b0;
                if (slot_ok && func_t'(req.func) == FUNC_SET_ONE)
                begin
                    periods_reg[SLOT_W'(req.slot)] <= '0;
                end
                if (slot_ok && func_t'(req.func) == FUNC_SET_PER)
                begin
                    periods_reg[SLOT_W'(req.slot)] <= req.period_value;
                    starts_reg[SLOT_W'(req.slot)]  <= req.time_value;
                end
            end
        end
        if (state_reg == ST_REMOVE)
        begin
            per_reg <= periods_reg[slot_reg];
            st_reg  <= starts_reg[slot_reg];
        end
        if (load_rsp)
        begin
            rsp_fired_reg <= fired_reg;
            rsp_slot_reg  <= fired_reg ? 3'(slot_reg) : 3'd0;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.fired      = rsp_fired_reg;
    assign rsp.fired_slot = rsp_slot_reg;

    `include "assert_macros.svh"

    `SAQ_ASSERT_NOW(a_cells_packed, 1'b1, $onehot(valid_vec + 1'b1) || (&valid_vec))
    `SAQ_ASSERT_NOW(a_div_in_div_state, state_reg == ST_DIV, div_busy || div_done)
    `SAQ_ASSERT_NOW(a_idle_slot_zero, rsp_valid_reg && !rsp_fired_reg, rsp_slot_reg == 3'd0)
    `SAQ_ASSERT_NEXT(a_insert_fills, state_reg == ST_INSERT, ents[0].valid)

endmodule
`default_nettype wire
